[src/sts_pkg.sv]
// ---------------------------------------------------------------------------
// Sine Taylor series package
// Widths, fixed-point constants and the divisor table shared by the sine
// series block and its arithmetic units.
// ---------------------------------------------------------------------------
package sts_pkg;

  localparam int ANG_W  = 32;  // input angle, signed Q8.24
  localparam int RED_W  = 33;  // range reduction register, signed
  localparam int XR_W   = 27;  // reduced angle, Q3.24, below 2pi
  localparam int TOL_W  = 31;  // tolerance register, Q1.30
  localparam int SINE_W = 32;  // sine result, signed Q2.30
  localparam int CNT_W  = 6;   // terms used
  localparam int IDX_W  = 5;   // term index into the divisor table
  localparam int TERM_W = 37;  // term magnitude, unsigned Q30
  localparam int X2_W   = 36;  // x squared, unsigned Q30
  localparam int PROD_W = TERM_W + X2_W;
  localparam int P_W    = PROD_W - 30;
  localparam int NUM_W  = P_W + 1;
  localparam int DEN_W  = 13;
  localparam int SUM_W  = 40;

  localparam logic signed [RED_W-1:0] TWO_PI_Q24 = 33'sd105414357;
  localparam logic signed [SUM_W-1:0] ONE_Q30    = 40'sd1073741824;
  localparam logic [TOL_W-1:0]        TOL_RESET  = 31'd1074;

  typedef logic [TERM_W-1:0] term_t;
  typedef logic [X2_W-1:0]   x2_t;
  typedef logic [PROD_W-1:0] prod_t;

  // Divisor that turns term n into term n+1: (2n+2)(2n+3).
  function automatic logic [DEN_W-1:0] den_of(input logic [IDX_W-1:0] n);
    logic [DEN_W-1:0] f0;
    logic [DEN_W-1:0] f1;
    logic [2*DEN_W-1:0] prod;
    f0   = DEN_W'({n, 1'b0}) + DEN_W'(2);
    f1   = f0 + DEN_W'(1);
    prod = f0 * f1;
    return prod[DEN_W-1:0];
  endfunction

endpackage

[src/sts_mac.sv]
// ---------------------------------------------------------------------------
// Sine Taylor series shared multiplier
// Forms a 37 x 36 bit unsigned product from four 19 x 19 bit partial
// products, one per cycle, each registered before it is accumulated.
// ---------------------------------------------------------------------------
module sts_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sts_pkg::term_t      a,
  input  sts_pkg::x2_t        b,
  output logic                done,
  output sts_pkg::prod_t      prod
);

  localparam int PP_W = 38;

  sts_pkg::term_t a_r;
  sts_pkg::x2_t   b_r;
  logic           busy_r;
  logic [1:0]     step_r;
  logic           pp_vld_r;
  logic [1:0]     pp_sel_r;
  logic [PP_W-1:0] pp_r;
  sts_pkg::prod_t acc_r;
  logic           done_r;

  logic [18:0]    opa;
  logic [18:0]    opb;
  sts_pkg::prod_t pp_ext;
  sts_pkg::prod_t pp_sh;

  always_comb begin
    unique case (step_r)
      2'd0: begin
        opa = a_r[18:0];
        opb = {1'b0, b_r[17:0]};
      end
      2'd1: begin
        opa = {1'b0, a_r[36:19]};
        opb = {1'b0, b_r[17:0]};
      end
      2'd2: begin
        opa = a_r[18:0];
        opb = {1'b0, b_r[35:18]};
      end
      default: begin
        opa = {1'b0, a_r[36:19]};
        opb = {1'b0, b_r[35:18]};
      end
    endcase
  end

  assign pp_ext = sts_pkg::PROD_W'(pp_r);

  always_comb begin
    unique case (pp_sel_r)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << 19;
      2'd2:    pp_sh = pp_ext << 18;
      default: pp_sh = pp_ext << 37;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      step_r   <= 2'd0;
      pp_vld_r <= 1'b0;
      pp_sel_r <= 2'd0;
      done_r   <= 1'b0;
    end else begin
      pp_vld_r <= busy_r;
      pp_sel_r <= step_r;
      done_r   <= pp_vld_r && (pp_sel_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r <= PP_W'(opa * opb);
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[src/sts_div.sv]
// ---------------------------------------------------------------------------
// Sine Taylor series divider
// Radix-4 restoring divider: two quotient bits per cycle by comparing the
// partial remainder against one, two and three times the divisor.
// ---------------------------------------------------------------------------
module sts_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sts_pkg::NUM_W-1:0]     num,
  input  logic [sts_pkg::DEN_W-1:0]     den,
  output logic                          done,
  output logic [sts_pkg::NUM_W-1:0]     quo
);

  localparam int ITER  = sts_pkg::NUM_W / 2;
  localparam int CNT_W = $clog2(ITER);
  localparam int R4_W  = sts_pkg::DEN_W + 2;

  logic                       busy_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       done_r;
  logic [sts_pkg::NUM_W-1:0]  num_r;
  logic [sts_pkg::NUM_W-1:0]  quo_r;
  logic [sts_pkg::DEN_W-1:0]  rem_r;
  logic [sts_pkg::DEN_W-1:0]  den_r;

  logic [R4_W-1:0] r4;
  logic [R4_W-1:0] d1;
  logic [R4_W-1:0] d2;
  logic [R4_W-1:0] d3;
  logic [R4_W-1:0] diff;
  logic [1:0]      digit;

  assign r4 = {rem_r, num_r[sts_pkg::NUM_W-1 -: 2]};
  assign d1 = R4_W'(den_r);
  assign d2 = R4_W'({den_r, 1'b0});
  assign d3 = d1 + d2;

  // The remainder stays below the divisor, so the digit never exceeds three.
  always_comb begin
    priority if (r4 >= d3) begin
      digit = 2'd3;
      diff  = r4 - d3;
    end else if (r4 >= d2) begin
      digit = 2'd2;
      diff  = r4 - d2;
    end else if (r4 >= d1) begin
      digit = 2'd1;
      diff  = r4 - d1;
    end else begin
      digit = 2'd0;
      diff  = r4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 2;
      rem_r <= diff[sts_pkg::DEN_W-1:0];
      quo_r <= {quo_r[sts_pkg::NUM_W-3:0], digit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[src/sine_taylor_series.sv]
// ---------------------------------------------------------------------------
// Sine by Taylor series
// Reduces a Q8.24 angle into [0, 2pi), then sums alternating Taylor terms
// until a term falls to the tolerance or the term cap is reached, and
// returns the saturated Q2.30 sine with the number of terms added.
// ---------------------------------------------------------------------------
//  channel  direction  payload (low bits first)
//  in_      slave      angle[31:0]
//  out_     master     sine[31:0], terms_used[37:32], zero pad[39:38]
//  cfg_     write      tolerance[30:0]
//
// Range reduction adds or subtracts 2pi until the angle lies in [0, 2pi),
// at most 21 steps; the series then adds up to MAX_TERMS terms. Each
// term passes one check, the shared multiplier (four partial products
// and two register stages), a divider load and the radix-4 divider.
// in_tready is high only while no angle is in progress. A finished result
// waits in the output register, so a new angle may be taken while it stalls.
// Reset is synchronous; it empties the output and sets tolerance to 1074.
// ---------------------------------------------------------------------------
module sine_taylor_series #(
  parameter int MAX_TERMS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sts_pkg::TOL_W-1:0]   cfg_wdata,   // tolerance
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,    // angle[31:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata    // sine[31:0], terms_used[37:32]
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_PRE  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam int W = sts_pkg::SUM_W;

  logic [2:0]                         state_r;
  logic [sts_pkg::TOL_W-1:0]          tol_r;
  logic signed [sts_pkg::RED_W-1:0]   red_r;
  sts_pkg::term_t                     term_r;
  sts_pkg::x2_t                       x2_r;
  logic [sts_pkg::P_W-1:0]            p_r;
  logic [sts_pkg::DEN_W-1:0]          d_r;
  logic signed [W-1:0]                sum_r;
  logic [sts_pkg::CNT_W-1:0]          n_r;
  logic                               out_vld_r;
  logic [sts_pkg::SINE_W-1:0]         out_sine_r;
  logic [sts_pkg::CNT_W-1:0]          out_cnt_r;

  logic                               mac_start;
  sts_pkg::term_t                     mac_a;
  sts_pkg::x2_t                       mac_b;
  logic                               mac_done;
  sts_pkg::prod_t                     mac_prod;
  sts_pkg::prod_t                     sq_round;
  sts_pkg::prod_t                     p_round;
  logic                               div_start;
  logic [sts_pkg::NUM_W-1:0]          div_num;
  logic                               div_done;
  logic [sts_pkg::NUM_W-1:0]          div_quo;

  logic                               red_neg;
  logic                               red_high;
  logic                               term_small;
  logic                               last_term;
  logic signed [W-1:0]                term_s;
  logic signed [W-1:0]                sum_sat;
  logic                               out_free;

  assign red_neg    = red_r < 0;
  assign red_high   = red_r >= sts_pkg::TWO_PI_Q24;
  assign term_small = term_r <= sts_pkg::TERM_W'(tol_r);
  assign last_term  = (n_r + sts_pkg::CNT_W'(1)) == sts_pkg::CNT_W'(MAX_TERMS);
  assign term_s     = signed'(W'(term_r));
  assign out_free   = !out_vld_r || out_tready;

  assign mac_start = ((state_r == S_RED) && !red_neg && !red_high) ||
                     ((state_r == S_CHK) && !term_small && !last_term);
  assign mac_a     = (state_r == S_RED) ? sts_pkg::TERM_W'(red_r[sts_pkg::XR_W-1:0]) : term_r;
  assign mac_b     = (state_r == S_RED) ? sts_pkg::X2_W'(red_r[sts_pkg::XR_W-1:0]) : x2_r;

  // Round half up before dropping the fraction bits.
  assign sq_round  = mac_prod + sts_pkg::PROD_W'(1 << 17);
  assign p_round   = mac_prod + sts_pkg::PROD_W'(1 << 29);

  assign div_start = (state_r == S_PRE);
  assign div_num   = sts_pkg::NUM_W'(p_r) + sts_pkg::NUM_W'(d_r[sts_pkg::DEN_W-1:1]);

  always_comb begin
    priority if (sum_r > sts_pkg::ONE_Q30) begin
      sum_sat = sts_pkg::ONE_Q30;
    end else if (sum_r < -sts_pkg::ONE_Q30) begin
      sum_sat = -sts_pkg::ONE_Q30;
    end else begin
      sum_sat = sum_r;
    end
  end

  sts_mac u_sts_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a     (mac_a),
    .b     (mac_b),
    .done  (mac_done),
    .prod  (mac_prod)
  );

  sts_div u_sts_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tol_r     <= sts_pkg::TOL_RESET;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_RED;
          end
        end
        S_RED: begin
          if (!red_neg && !red_high) begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (mac_done) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (term_small || last_term) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mac_done) begin
            state_r <= S_PRE;
          end
        end
        S_PRE: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_CHK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_tvalid) begin
      red_r <= sts_pkg::RED_W'(signed'(in_tdata));
    end
    if (state_r == S_RED) begin
      if (red_neg) begin
        red_r <= red_r + sts_pkg::TWO_PI_Q24;
      end else if (red_high) begin
        red_r <= red_r - sts_pkg::TWO_PI_Q24;
      end else begin
        term_r <= {4'b0, red_r[sts_pkg::XR_W-1:0], 6'b0};
      end
    end
    if ((state_r == S_SQ) && mac_done) begin
      x2_r  <= sq_round[sts_pkg::X2_W+17:18];
      n_r   <= '0;
      sum_r <= '0;
    end
    if ((state_r == S_CHK) && !term_small) begin
      sum_r <= n_r[0] ? (sum_r - term_s) : (sum_r + term_s);
      n_r   <= n_r + sts_pkg::CNT_W'(1);
      d_r   <= sts_pkg::den_of(n_r[sts_pkg::IDX_W-1:0]);
    end
    if ((state_r == S_MUL) && mac_done) begin
      p_r <= p_round[sts_pkg::PROD_W-1:30];
    end
    if ((state_r == S_DIV) && div_done) begin
      term_r <= div_quo[sts_pkg::TERM_W-1:0];
    end
    if ((state_r == S_DONE) && out_free) begin
      out_sine_r <= sum_sat[sts_pkg::SINE_W-1:0];
      out_cnt_r  <= n_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b0, out_cnt_r, out_sine_r};

endmodule

[src/sts_chk.sv]
// ---------------------------------------------------------------------------
// Sine Taylor series port checker
// Watches the top level's channels and flags handshake breaks on either
// channel and results that fall outside the range of a saturated sine.
// ---------------------------------------------------------------------------
module sts_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata
);

  logic signed [31:0] sine;
  logic [5:0]         terms;

  assign sine  = signed'(out_tdata[31:0]);
  assign terms = out_tdata[37:32];

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // An accepted angle starts range reduction, so the input closes right after a transaction.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted angle");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((sine <= 32'sd1073741824) && (sine >= -32'sd1073741824) &&
                    (terms <= 6'd32) && (out_tdata[39:38] == 2'b00)))
    else $error("result out of range");

  // With no term added the sum is still zero.
  a_zero_terms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (terms == 6'd0)) |-> (sine == 32'sd0))
    else $error("nonzero sine with no terms");

  logic unused_in;
  assign unused_in = ^in_tdata;

endmodule

bind sine_taylor_series sts_chk u_sts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
